// ===== rtl/ctp_pkg.sv =====
// package for the countdown timer pool
// operation codes, field widths and beat payload types; no dependencies
`default_nettype none

package ctp_pkg;

  localparam int OP_W     = 3;
  localparam int HANDLE_W = 8;
  localparam int TIME_W   = 32;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_CREATE = 3'd1,
    OP_DELETE = 3'd2,
    OP_READ   = 3'd3,
    OP_SET    = 3'd4
  } ctp_op_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   time_value;
  } ctp_cmd_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] new_handle;
    logic [TIME_W-1:0]   remaining;
    logic                bad_handle;
  } ctp_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ctp_if.sv =====
// valid/ready channel interfaces for the countdown timer pool
// depends on ctp_pkg for field widths
`default_nettype none

interface ctp_in_if import ctp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [HANDLE_W-1:0] handle;
  logic [TIME_W-1:0]   time_value;

  modport source (output valid, output op, output handle, output time_value, input ready);
  modport sink   (input valid, input op, input handle, input time_value, output ready);
endinterface

interface ctp_out_if import ctp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] new_handle;
  logic [TIME_W-1:0]   remaining;
  logic                bad_handle;

  modport source (output valid, output new_handle, output remaining, output bad_handle,
                  input ready);
  modport sink   (input valid, input new_handle, input remaining, input bad_handle,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/countdown_timer_pool.sv =====
// countdown timer pool top level: timer bank, op decode and result register
// depends on ctp_pkg and the channel interfaces in ctp_if
//
//   channel   direction  beat contents
//   in_cmd    in         op, handle, time_value
//   out_rsp   out        new_handle, remaining, bad_handle
//
// one beat is taken per cycle while ready; its result is registered at the accept
// the timer bank and first-free search update in the same cycle as the accept
// in_cmd.ready drops only while a held result is not taken by out_rsp
// synchronous active-low reset disables all timers and clears their times
`default_nettype none

module countdown_timer_pool import ctp_pkg::*; #(
  parameter int NUM_TIMERS = 8
) (
  input  wire        clk,
  input  wire        rst_n,
  ctp_in_if.sink     in_cmd,
  ctp_out_if.source  out_rsp
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic [NUM_TIMERS-1:0] en_r, en_nxt;
  logic [TIME_W-1:0]     time_r   [NUM_TIMERS];
  logic [TIME_W-1:0]     time_nxt [NUM_TIMERS];
  logic                  out_valid_r;
  ctp_rsp_t              rsp_r, rsp_nxt;

  logic                  accept;
  logic                  hdl_ok;
  logic [IDX_W-1:0]      hdl_idx;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;

  assign in_cmd.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_cmd.valid && in_cmd.ready;

  assign hdl_ok  = (in_cmd.handle != '0) && (in_cmd.handle <= HANDLE_W'(NUM_TIMERS));
  assign hdl_idx = IDX_W'(in_cmd.handle - HANDLE_W'(1));

  // lowest disabled slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!en_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    en_nxt  = en_r;
    rsp_nxt = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      time_nxt[i] = time_r[i];
    end
    unique case (in_cmd.op)
      OP_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (en_r[i] && time_r[i] != '0) begin
            time_nxt[i] = time_r[i] - TIME_W'(1);
          end
        end
      end
      OP_CREATE: begin
        if (free_found) begin
          en_nxt[free_idx]   = 1'b1;
          time_nxt[free_idx] = in_cmd.time_value;
          rsp_nxt.new_handle = HANDLE_W'(free_idx) + HANDLE_W'(1);
        end
      end
      OP_DELETE: begin
        rsp_nxt.bad_handle = !hdl_ok;
        if (hdl_ok) begin
          en_nxt[hdl_idx] = 1'b0;
        end
      end
      OP_READ: begin
        rsp_nxt.bad_handle = !hdl_ok;
        if (hdl_ok) begin
          rsp_nxt.remaining = time_r[hdl_idx];
        end
      end
      OP_SET: begin
        rsp_nxt.bad_handle = !hdl_ok;
        if (hdl_ok) begin
          time_nxt[hdl_idx] = in_cmd.time_value;
        end
      end
      default: begin
        rsp_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        time_r[i] <= '0;
      end
    end else begin
      if (accept) begin
        en_r        <= en_nxt;
        out_valid_r <= 1'b1;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          time_r[i] <= time_nxt[i];
        end
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.new_handle = rsp_r.new_handle;
  assign out_rsp.remaining  = rsp_r.remaining;
  assign out_rsp.bad_handle = rsp_r.bad_handle;

endmodule

`default_nettype wire
